// ----- src/wipq_pkg.sv -----
// Package for the work-item pool queue manager.
// Holds the command codes, the sequencer states and the queued transaction type.
// No dependencies.
package wipq_pkg;

    localparam int CMD_W  = 2;
    localparam int CORE_W = 3;
    localparam int SLOT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_ENQUEUE = 2'd2,
        OP_DEQUEUE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ALLOC,
        ST_ENQ,
        ST_DEQ_HEAD,
        ST_DEQ_LINK
    } state_t;

    // One classified command waiting between the front and the back.
    typedef struct packed {
        op_t               op;
        logic [CORE_W-1:0] core;
        logic [SLOT_W-1:0] slot;
        logic              slot_ok;
        logic              core_ok;
    } item_t;

endpackage

// ----- src/wipq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module wipq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/wipq_front.sv -----
// Front end: accepts command transactions, range-checks slot and core,
// and holds them in a two-entry queue for the back end. Uses wipq_pkg.
module wipq_front #(
    parameter int POOL_SLOTS = 32,
    parameter int CORE_COUNT = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          enable,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [wipq_pkg::CMD_W-1:0]    cmd,
    input  logic [wipq_pkg::CORE_W-1:0]   core,
    input  logic [wipq_pkg::SLOT_W-1:0]   slot,
    output logic                          item_valid,
    output wipq_pkg::item_t               item,
    input  logic                          item_pop
);

    localparam int CMPW = 12;

    wipq_pkg::item_t fifo_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            push;
    wipq_pkg::item_t new_item;

    always_comb
    begin
        new_item.op      = wipq_pkg::op_t'(cmd);
        new_item.core    = core;
        new_item.slot    = slot;
        new_item.slot_ok = CMPW'(slot) < CMPW'(POOL_SLOTS);
        new_item.core_ok = CMPW'(core) < CMPW'(CORE_COUNT);
    end

    assign in_stall   = !enable || (count_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign item_valid = (count_reg != 2'd0);
    assign item       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = item_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(item_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ----- src/wipq_back.sv -----
// Back end: sequencer that carries out alloc, free, enqueue and dequeue on the
// shared link store, the queue head and tail stores and the free-list head.
// Uses wipq_pkg and wipq_ram.
module wipq_back #(
    parameter int POOL_SLOTS = 32,
    parameter int CORE_COUNT = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    output logic                          ready,
    input  logic                          item_valid,
    input  wipq_pkg::item_t               item,
    output logic                          item_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic [wipq_pkg::SLOT_W-1:0]   slot_out
);

    localparam int PW   = $clog2(POOL_SLOTS + 1);
    localparam int SIW  = $clog2(POOL_SLOTS);
    localparam int CIW  = CORE_COUNT > 1 ? $clog2(CORE_COUNT) : 1;
    localparam int CXW  = CIW + wipq_pkg::CORE_W;
    localparam int SXW  = SIW + wipq_pkg::SLOT_W;
    localparam logic [PW-1:0]  LINK_NONE = PW'(POOL_SLOTS);
    localparam logic [SIW-1:0] LAST_SLOT = SIW'(POOL_SLOTS - 1);

    wipq_pkg::state_t state_reg, state_next;
    logic [SIW-1:0]        init_cnt_reg, init_cnt_next;
    logic [PW-1:0]         free_head_reg, free_head_next;
    logic [CORE_COUNT-1:0] nonempty_reg, nonempty_next;
    logic [CIW-1:0]        cur_core_reg, cur_core_next;
    logic [SIW-1:0]        cur_slot_reg, cur_slot_next;
    logic [SIW-1:0]        cur_ptr_reg, cur_ptr_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_ok_reg, out_ok_next;
    logic [SIW-1:0]        out_ptr_reg, out_ptr_next;

    logic           link_we, heads_we, tails_we;
    logic [SIW-1:0] link_waddr, link_raddr;
    logic [PW-1:0]  link_wdata, link_rdata;
    logic [CIW-1:0] heads_waddr, heads_raddr, tails_waddr, tails_raddr;
    logic [SIW-1:0] heads_wdata, tails_wdata, heads_rdata, tails_rdata;

    logic           out_free, load;
    logic [CXW-1:0] core_wide;
    logic [CIW-1:0] core_idx;
    logic [SXW-1:0] slot_wide;
    logic [SIW-1:0] slot_idx;
    logic [SXW-1:0] res_wide;
    logic           head_ok, link_is_slot;

    assign core_wide    = CXW'(item.core);
    assign core_idx     = core_wide[CIW-1:0];
    assign slot_wide    = SXW'(item.slot);
    assign slot_idx     = slot_wide[SIW-1:0];
    assign res_wide     = SXW'(out_ptr_reg);
    assign out_free     = !out_valid_reg || !out_stall;
    assign head_ok      = free_head_reg < LINK_NONE;
    assign link_is_slot = link_rdata < LINK_NONE;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wipq_pkg::ST_INIT:
            begin
                if (init_cnt_reg == LAST_SLOT)
                begin
                    state_next = wipq_pkg::ST_IDLE;
                end
            end
            wipq_pkg::ST_IDLE:
            begin
                if (item_valid && out_free)
                begin
                    case (item.op)
                        wipq_pkg::OP_ALLOC:
                        begin
                            if (head_ok)
                            begin
                                state_next = wipq_pkg::ST_ALLOC;
                            end
                        end
                        wipq_pkg::OP_ENQUEUE:
                        begin
                            if (item.slot_ok && item.core_ok && nonempty_reg[core_idx])
                            begin
                                state_next = wipq_pkg::ST_ENQ;
                            end
                        end
                        wipq_pkg::OP_DEQUEUE:
                        begin
                            if (item.core_ok && nonempty_reg[core_idx])
                            begin
                                state_next = wipq_pkg::ST_DEQ_HEAD;
                            end
                        end
                        default:
                        begin
                            state_next = wipq_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            wipq_pkg::ST_DEQ_HEAD:
            begin
                state_next = wipq_pkg::ST_DEQ_LINK;
            end
            wipq_pkg::ST_ALLOC, wipq_pkg::ST_ENQ, wipq_pkg::ST_DEQ_LINK:
            begin
                state_next = wipq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = wipq_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and store controls.
    always_comb
    begin
        init_cnt_next  = init_cnt_reg;
        free_head_next = free_head_reg;
        nonempty_next  = nonempty_reg;
        cur_core_next  = cur_core_reg;
        cur_slot_next  = cur_slot_reg;
        cur_ptr_next   = cur_ptr_reg;
        item_pop       = 1'b0;
        load           = 1'b0;
        out_ok_next    = out_ok_reg;
        out_ptr_next   = out_ptr_reg;
        link_we        = 1'b0;
        link_waddr     = '0;
        link_wdata     = LINK_NONE;
        link_raddr     = '0;
        heads_we       = 1'b0;
        heads_waddr    = '0;
        heads_wdata    = '0;
        heads_raddr    = '0;
        tails_we       = 1'b0;
        tails_waddr    = '0;
        tails_wdata    = '0;
        tails_raddr    = '0;

        case (state_reg)
            wipq_pkg::ST_INIT:
            begin
                // Clearing pass: each link entry points at the next slot.
                link_we       = 1'b1;
                link_waddr    = init_cnt_reg;
                link_wdata    = PW'(init_cnt_reg) + PW'(1);
                init_cnt_next = init_cnt_reg + SIW'(1);
            end
            wipq_pkg::ST_IDLE:
            begin
                if (item_valid && out_free)
                begin
                    item_pop      = 1'b1;
                    cur_core_next = core_idx;
                    cur_slot_next = slot_idx;
                    out_ok_next   = 1'b0;
                    out_ptr_next  = '0;
                    case (item.op)
                        wipq_pkg::OP_ALLOC:
                        begin
                            if (head_ok)
                            begin
                                link_raddr   = free_head_reg[SIW-1:0];
                                cur_ptr_next = free_head_reg[SIW-1:0];
                            end
                            else
                            begin
                                load = 1'b1;
                            end
                        end
                        wipq_pkg::OP_FREE:
                        begin
                            load = 1'b1;
                            if (item.slot_ok)
                            begin
                                link_we        = 1'b1;
                                link_waddr     = slot_idx;
                                link_wdata     = free_head_reg;
                                free_head_next = PW'(slot_idx);
                                out_ok_next    = 1'b1;
                            end
                        end
                        wipq_pkg::OP_ENQUEUE:
                        begin
                            if (item.slot_ok && item.core_ok)
                            begin
                                link_we    = 1'b1;
                                link_waddr = slot_idx;
                                link_wdata = LINK_NONE;
                                if (nonempty_reg[core_idx])
                                begin
                                    tails_raddr = core_idx;
                                end
                                else
                                begin
                                    heads_we                = 1'b1;
                                    heads_waddr             = core_idx;
                                    heads_wdata             = slot_idx;
                                    tails_we                = 1'b1;
                                    tails_waddr             = core_idx;
                                    tails_wdata             = slot_idx;
                                    nonempty_next[core_idx] = 1'b1;
                                    out_ok_next             = 1'b1;
                                    load                    = 1'b1;
                                end
                            end
                            else
                            begin
                                load = 1'b1;
                            end
                        end
                        wipq_pkg::OP_DEQUEUE:
                        begin
                            if (item.core_ok && nonempty_reg[core_idx])
                            begin
                                heads_raddr = core_idx;
                            end
                            else
                            begin
                                load = 1'b1;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            wipq_pkg::ST_ALLOC:
            begin
                free_head_next = link_rdata;
                link_we        = 1'b1;
                link_waddr     = cur_ptr_reg;
                link_wdata     = LINK_NONE;
                out_ok_next    = 1'b1;
                out_ptr_next   = cur_ptr_reg;
                load           = 1'b1;
            end
            wipq_pkg::ST_ENQ:
            begin
                // The queue is not empty, so the stored tail is a real slot.
                link_we     = 1'b1;
                link_waddr  = tails_rdata;
                link_wdata  = PW'(cur_slot_reg);
                tails_we    = 1'b1;
                tails_waddr = cur_core_reg;
                tails_wdata = cur_slot_reg;
                out_ok_next = 1'b1;
                load        = 1'b1;
            end
            wipq_pkg::ST_DEQ_HEAD:
            begin
                link_raddr   = heads_rdata;
                cur_ptr_next = heads_rdata;
            end
            wipq_pkg::ST_DEQ_LINK:
            begin
                heads_we    = 1'b1;
                heads_waddr = cur_core_reg;
                heads_wdata = link_rdata[SIW-1:0];
                if (!link_is_slot)
                begin
                    nonempty_next[cur_core_reg] = 1'b0;
                end
                out_ok_next  = 1'b1;
                out_ptr_next = cur_ptr_reg;
                load         = 1'b1;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase

        out_valid_next = load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wipq_pkg::ST_INIT;
            init_cnt_reg  <= '0;
            free_head_reg <= '0;
            nonempty_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            free_head_reg <= free_head_next;
            nonempty_reg  <= nonempty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_core_reg <= cur_core_next;
        cur_slot_reg <= cur_slot_next;
        cur_ptr_reg  <= cur_ptr_next;
        out_ok_reg   <= out_ok_next;
        out_ptr_reg  <= out_ptr_next;
    end

    wipq_ram #(.WIDTH(PW), .DEPTH(POOL_SLOTS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    wipq_ram #(.WIDTH(SIW), .DEPTH(CORE_COUNT)) u_heads_ram (
        .clk   (clk),
        .we    (heads_we),
        .waddr (heads_waddr),
        .wdata (heads_wdata),
        .raddr (heads_raddr),
        .rdata (heads_rdata)
    );

    wipq_ram #(.WIDTH(SIW), .DEPTH(CORE_COUNT)) u_tails_ram (
        .clk   (clk),
        .we    (tails_we),
        .waddr (tails_waddr),
        .wdata (tails_wdata),
        .raddr (tails_raddr),
        .rdata (tails_rdata)
    );

    assign ready     = (state_reg != wipq_pkg::ST_INIT);
    assign out_valid = out_valid_reg;
    assign ok        = out_ok_reg;
    assign slot_out  = res_wide[wipq_pkg::SLOT_W-1:0];

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> (state_reg == wipq_pkg::ST_IDLE))
        else $error("command taken outside the idle state");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> out_free)
        else $error("result loaded over an unaccepted result");

    a_alloc_succeeds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wipq_pkg::ST_ALLOC) |=> (out_valid_reg && out_ok_reg))
        else $error("alloc from a non-empty free list did not report success");

    a_deq_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wipq_pkg::ST_DEQ_HEAD) |=> (state_reg == wipq_pkg::ST_DEQ_LINK))
        else $error("dequeue head read not followed by link read");

endmodule

// ----- src/work_item_pool_queue_manager.sv -----
// Work-item pool queue manager: a pool of POOL_SLOTS slots with one free list
// and CORE_COUNT per-core FIFO queues, all linked through one next-pointer RAM.
//
// Input channel (in_valid/in_stall) carries one command per transaction:
// cmd selects alloc, free, enqueue or dequeue; core and slot are its operands.
// Output channel (out_valid/out_stall) returns one result per command:
// ok, and slot_out holding the allocated or dequeued slot (zero otherwise).
// Commands are executed one at a time, in order.
//
// Free, enqueue to an empty queue and any failing command are answered from
// the idle state; alloc passes through ST_ALLOC, enqueue to a non-empty queue
// through ST_ENQ, and dequeue through ST_DEQ_HEAD and then ST_DEQ_LINK. The
// sequencer walks the link, head and tail RAMs through their single registered
// read port, so it takes no new command until the current one has finished.
// A two-entry queue sits in front of the sequencer.
//
// After reset the block runs a clearing pass that chains every slot onto the
// free list; in_stall stays high during it. When out_stall holds a result,
// the next command waits in the queue and in_stall rises once the queue is
// full.
module work_item_pool_queue_manager #(
    parameter int POOL_SLOTS = 32,
    parameter int CORE_COUNT = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [wipq_pkg::CMD_W-1:0]    cmd,
    input  logic [wipq_pkg::CORE_W-1:0]   core,
    input  logic [wipq_pkg::SLOT_W-1:0]   slot,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic [wipq_pkg::SLOT_W-1:0]   slot_out
);

    logic            back_ready;
    logic            item_valid;
    logic            item_pop;
    wipq_pkg::item_t item;

    wipq_front #(.POOL_SLOTS(POOL_SLOTS), .CORE_COUNT(CORE_COUNT)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (back_ready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .core       (core),
        .slot       (slot),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    wipq_back #(.POOL_SLOTS(POOL_SLOTS), .CORE_COUNT(CORE_COUNT)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ready      (back_ready),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ok         (ok),
        .slot_out   (slot_out)
    );

endmodule

// ----- sim/work_item_pool_queue_manager_tb.sv -----
// Testbench for the work-item pool queue manager: drives commands with random gaps,
// predicts every result from its own copy of the free list and per-core queues.
// Depends on wipq_pkg and work_item_pool_queue_manager from src.
`timescale 1ns / 1ps

module work_item_pool_queue_manager_tb;

    localparam int POOL_SLOTS = 32;
    localparam int CORE_COUNT = 8;
    localparam logic [wipq_pkg::SLOT_W:0] LINK_NONE = (wipq_pkg::SLOT_W+1)'(POOL_SLOTS);
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 250;
    localparam int RANDOM_ITEMS = 1130;
    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic                        ok;
        logic [wipq_pkg::SLOT_W-1:0] slot;
    } outcome_t;

    class slot_pool_scoreboard;
        logic [wipq_pkg::SLOT_W:0]   next_link [POOL_SLOTS];
        logic [wipq_pkg::SLOT_W:0]   free_head;
        logic [wipq_pkg::SLOT_W:0]   queue_head [CORE_COUNT];
        logic [wipq_pkg::SLOT_W:0]   queue_tail [CORE_COUNT];
        outcome_t                    expected_q [$];
        logic [wipq_pkg::SLOT_W-1:0] spare [$];
        int                          mismatches;

        function new();
            for (int i = 0; i < POOL_SLOTS; i++)
            begin
                next_link[i] = (wipq_pkg::SLOT_W+1)'(i + 1);
            end
            free_head = '0;
            for (int c = 0; c < CORE_COUNT; c++)
            begin
                queue_head[c] = LINK_NONE;
                queue_tail[c] = LINK_NONE;
            end
            mismatches = 0;
        endfunction

        function void note_command(wipq_pkg::op_t op, logic [wipq_pkg::CORE_W-1:0] core,
                                   logic [wipq_pkg::SLOT_W-1:0] slot);
            outcome_t                  res;
            logic [wipq_pkg::SLOT_W:0] p;
            res = '0;
            case (op)
                wipq_pkg::OP_ALLOC:
                begin
                    p = free_head;
                    if (p < LINK_NONE)
                    begin
                        free_head = next_link[p[wipq_pkg::SLOT_W-1:0]];
                        next_link[p[wipq_pkg::SLOT_W-1:0]] = LINK_NONE;
                        res.ok = 1'b1;
                        res.slot = p[wipq_pkg::SLOT_W-1:0];
                    end
                end
                wipq_pkg::OP_FREE:
                begin
                    if (int'(slot) < POOL_SLOTS)
                    begin
                        next_link[slot] = free_head;
                        free_head = {1'b0, slot};
                        res.ok = 1'b1;
                    end
                end
                wipq_pkg::OP_ENQUEUE:
                begin
                    if (int'(slot) < POOL_SLOTS && int'(core) < CORE_COUNT)
                    begin
                        next_link[slot] = LINK_NONE;
                        p = queue_tail[core];
                        if (p < LINK_NONE)
                            next_link[p[wipq_pkg::SLOT_W-1:0]] = {1'b0, slot};
                        else
                            queue_head[core] = {1'b0, slot};
                        queue_tail[core] = {1'b0, slot};
                        res.ok = 1'b1;
                    end
                end
                default:
                begin
                    if (int'(core) < CORE_COUNT)
                    begin
                        p = queue_head[core];
                        if (p < LINK_NONE)
                        begin
                            queue_head[core] = next_link[p[wipq_pkg::SLOT_W-1:0]];
                            if (!(queue_head[core] < LINK_NONE))
                                queue_tail[core] = LINK_NONE;
                            res.ok = 1'b1;
                            res.slot = p[wipq_pkg::SLOT_W-1:0];
                        end
                    end
                end
            endcase
            expected_q.push_back(res);
        endfunction

        // Collects the slots that sit on no list, walking each list at most
        // POOL_SLOTS steps since misuse can leave cycles behind.
        function void refresh_spare();
            bit                        listed [POOL_SLOTS];
            logic [wipq_pkg::SLOT_W:0] p;
            int                        steps;
            foreach (listed[i])
            begin
                listed[i] = 1'b0;
            end
            for (int c = -1; c < CORE_COUNT; c++)
            begin
                p = (c < 0) ? free_head : queue_head[c];
                steps = 0;
                while (p < LINK_NONE && steps < POOL_SLOTS)
                begin
                    listed[p[wipq_pkg::SLOT_W-1:0]] = 1'b1;
                    p = next_link[p[wipq_pkg::SLOT_W-1:0]];
                    steps++;
                end
            end
            spare.delete();
            for (int i = 0; i < POOL_SLOTS; i++)
            begin
                if (!listed[i])
                    spare.push_back(wipq_pkg::SLOT_W'(i));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Printing stops after a cap so a broken block cannot flood the log.
        task report(string msg);
            if (mismatches < PRINT_CAP)
                $display("%0t ns MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic ok, logic [wipq_pkg::SLOT_W-1:0] slot_out);
            outcome_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with no transaction outstanding: ok=%0b slot_out=%0d",
                                 ok, slot_out));
                return;
            end
            want = expected_q.pop_front();
            if (ok !== want.ok)
                report($sformatf("ok is %0b, predicted %0b", ok, want.ok));
            if (slot_out !== want.slot)
                report($sformatf("slot_out is %0d, predicted %0d", slot_out, want.slot));
        endtask
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [wipq_pkg::CMD_W-1:0]  cmd;
    logic [wipq_pkg::CORE_W-1:0] core;
    logic [wipq_pkg::SLOT_W-1:0] slot;
    logic                        out_valid;
    logic                        out_stall;
    logic                        ok;
    logic [wipq_pkg::SLOT_W-1:0] slot_out;

    slot_pool_scoreboard sb = new();
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    bit hold_req = 1'b0;
    int idle_cycles = 0;

    work_item_pool_queue_manager #(
        .POOL_SLOTS (POOL_SLOTS),
        .CORE_COUNT (CORE_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .core      (core),
        .slot      (slot),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ok        (ok),
        .slot_out  (slot_out)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offers one command and returns at the edge where the transaction is taken.
    task automatic issue(wipq_pkg::op_t op, logic [wipq_pkg::CORE_W-1:0] c,
                         logic [wipq_pkg::SLOT_W-1:0] s);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 49) == 0)
            tx_burst = !tx_burst;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        core <= c;
        slot <= s;
        do @(posedge clk); while (in_stall);
        sb.note_command(op, c, s);
    endtask

    initial
    begin
        wipq_pkg::op_t               op;
        logic [wipq_pkg::CORE_W-1:0] c;
        logic [wipq_pkg::SLOT_W-1:0] s;
        int                          pick;
        bit                          fill;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        cmd <= wipq_pkg::OP_ALLOC;
        core <= '0;
        slot <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        issue(wipq_pkg::OP_DEQUEUE, 3'd7, 5'd0);      // empty queue
        issue(wipq_pkg::OP_ALLOC,   3'd0, 5'd0);
        issue(wipq_pkg::OP_ALLOC,   3'd0, 5'd0);
        issue(wipq_pkg::OP_ENQUEUE, 3'd0, 5'd0);      // empty queue takes a head
        issue(wipq_pkg::OP_ENQUEUE, 3'd0, 5'd1);      // appended behind the tail
        issue(wipq_pkg::OP_ENQUEUE, 3'd7, 5'd31);     // slot still on the free list
        issue(wipq_pkg::OP_DEQUEUE, 3'd0, 5'd0);
        issue(wipq_pkg::OP_DEQUEUE, 3'd7, 5'd0);
        issue(wipq_pkg::OP_DEQUEUE, 3'd7, 5'd0);
        issue(wipq_pkg::OP_FREE,    3'd0, 5'd0);
        issue(wipq_pkg::OP_ALLOC,   3'd0, 5'd0);
        issue(wipq_pkg::OP_FREE,    3'd0, 5'd31);
        // Enqueuing the free-list head cuts the free list to one entry.
        issue(wipq_pkg::OP_ENQUEUE, 3'd5, 5'd31);
        issue(wipq_pkg::OP_ALLOC,   3'd0, 5'd0);
        issue(wipq_pkg::OP_ALLOC,   3'd0, 5'd0);      // free list empty
        issue(wipq_pkg::OP_FREE,    3'd0, 5'd21);
        issue(wipq_pkg::OP_FREE,    3'd0, 5'd10);
        issue(wipq_pkg::OP_ALLOC,   3'd0, 5'd0);
        issue(wipq_pkg::OP_ALLOC,   3'd0, 5'd0);
        issue(wipq_pkg::OP_ENQUEUE, 3'd2, 5'd10);
        issue(wipq_pkg::OP_DEQUEUE, 3'd5, 5'd0);
        issue(wipq_pkg::OP_DEQUEUE, 3'd2, 5'd0);
        issue(wipq_pkg::OP_DEQUEUE, 3'd3, 5'd0);

        // Mostly well-formed traffic: slots are freed or enqueued only while they
        // sit on no list. Phases alternate between filling and draining lists.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 300 || n == 850)
                hold_req = 1'b1;
            if (n == 600)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while (sb.pending() != 0);
            end
            fill = ((n / 100) % 2) == 0;
            sb.refresh_spare();
            c = ($urandom_range(0, 4) == 0) ? wipq_pkg::CORE_W'($urandom_range(0, 7))
                                            : wipq_pkg::CORE_W'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                op = wipq_pkg::op_t'($urandom_range(0, 3));
                s = wipq_pkg::SLOT_W'($urandom_range(0, 31));
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (fill)
                    op = (pick < 35) ? wipq_pkg::OP_ALLOC :
                         (pick < 45) ? wipq_pkg::OP_FREE :
                         (pick < 85) ? wipq_pkg::OP_ENQUEUE : wipq_pkg::OP_DEQUEUE;
                else
                    op = (pick < 15) ? wipq_pkg::OP_ALLOC :
                         (pick < 45) ? wipq_pkg::OP_FREE :
                         (pick < 65) ? wipq_pkg::OP_ENQUEUE : wipq_pkg::OP_DEQUEUE;
                if (sb.spare.size() == 0 &&
                    (op == wipq_pkg::OP_FREE || op == wipq_pkg::OP_ENQUEUE))
                    op = fill ? wipq_pkg::OP_ALLOC : wipq_pkg::OP_DEQUEUE;
                if (sb.spare.size() != 0 &&
                    (op == wipq_pkg::OP_FREE || op == wipq_pkg::OP_ENQUEUE))
                    s = sb.spare[$urandom_range(0, sb.spare.size() - 1)];
                else
                    s = wipq_pkg::SLOT_W'($urandom_range(0, 31));
            end
            issue(op, c, s);
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("work_item_pool_queue_manager_tb passed");
        else
            $display("work_item_pool_queue_manager_tb failed");
        $finish;
    end

    // Result side: random stall before each transaction, with an occasional
    // long hold that backs the block up into its input.
    initial
    begin
        int hold_for;
        forever
        begin
            if (hold_req)
            begin
                hold_for = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
            begin
                hold_for = rx_burst ? 0 : $urandom_range(0, 15);
            end
            if ($urandom_range(0, 49) == 0)
                rx_burst = !rx_burst;
            if (hold_for > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_for) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            sb.check_result(ok, slot_out);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("work_item_pool_queue_manager_tb failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
